[hdl/cemidp_pkg.sv]
// ----------------------------------------------------------------------------
// cemidp_pkg
// Shared constants, datapath commands and status bundle for the polygon
// interval dp block.
// ----------------------------------------------------------------------------
package cemidp_pkg;

  localparam int MaxVerticesDef = 32;
  localparam int DataW          = 64;
  localparam int ValW           = 16;
  localparam int EdgeW          = 6;
  localparam int HalfW          = 32;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  // edge operator codes
  localparam logic OpAdd = 1'b0;
  localparam logic OpMul = 1'b1;

  // datapath commands issued by the controller
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_L1_RD,
    CMD_L1_WR,
    CMD_SEG_START,
    CMD_RD_L,
    CMD_RD_R,
    CMD_CAP,
    CMD_ADD,
    CMD_MUL_INIT,
    CMD_MUL_P,
    CMD_MUL_A,
    CMD_MUL_S,
    CMD_MERGE,
    CMD_SEG_WR,
    CMD_IDX_CLR,
    CMD_B_RD,
    CMD_B_CMP,
    CMD_O_RD,
    CMD_O_CHK,
    CMD_O_SENT
  } dp_cmd_e;

  // status flags returned by the datapath
  typedef struct packed {
    logic last_vertex;
    logic n_one;
    logic l_last;
    logic len_last;
    logic k_last;
    logic is_mul;
    logic q_last;
    logic pi_last;
    logic i_last;
    logic match;
    logic out_last;
  } dp_status_t;

endpackage

[hdl/cemidp_ram.sv]
// ----------------------------------------------------------------------------
// cemidp_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module cemidp_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cemidp_dp.sv]
// ----------------------------------------------------------------------------
// cemidp_dp
// Datapath: vertex stores, interval max/min memories, loop counters,
// saturating adder, shared 32x32 multiplier and result registers.
// ----------------------------------------------------------------------------
module cemidp_dp #(
  parameter int MaxVertices = cemidp_pkg::MaxVerticesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cemidp_pkg::dp_cmd_e                  cmd_i,
  output cemidp_pkg::dp_status_t               status_o,
  input  logic                                 edge_op_i,
  input  logic signed [cemidp_pkg::ValW-1:0]   vertex_value_i,
  input  logic                                 last_vertex_i,
  output logic signed [cemidp_pkg::DataW-1:0]  best_value_o,
  output logic [cemidp_pkg::EdgeW-1:0]         removed_edge_o,
  output logic                                 last_result_o
);

  localparam int DW    = cemidp_pkg::DataW;
  localparam int HW    = cemidp_pkg::HalfW;
  localparam int CntW  = $clog2(MaxVertices + 1);
  localparam int LW    = $clog2(2 * MaxVertices);
  localparam int JW    = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int AW    = LW + JW;
  localparam int PW    = LW + 1;

  typedef logic signed [DW-1:0] word_t;

  // control registers
  logic [CntW-1:0] cnt_q, len_q, n_q;
  logic [LW-1:0]   l_q, k_q, i_q, last_idx_q;
  logic [1:0]      q_q, pi_q;
  logic            first_q, op_q, last_res_q;

  // payload registers
  word_t              lmax_q, lmin_q, rmax_q, rmin_q;
  word_t              hi_q, lo_q, chi_q, clo_q, best_q;
  logic [DW-1:0]      ua_q, ub_q;
  logic               neg_q;
  logic [DW-1:0]      prod_q;
  logic [2*DW-1:0]    acc_q;

  // memory ports
  logic            vs_we;
  logic [JW-1:0]   vs_waddr, vs_raddr;
  logic [cemidp_pkg::ValW-1:0] vs_rdata;
  logic [0:0]      os_rdata;
  logic            iv_we;
  logic [AW-1:0]   iv_waddr, iv_raddr;
  word_t           iv_wmax, iv_wmin;
  logic [DW-1:0]   iv_rmax, iv_rmin;

  // derived indexes
  logic [PW-1:0]   r_w, kp1_w, two_n;
  logic [LW-1:0]   kl_diff, rk_diff;
  logic [JW-1:0]   len_m1, n_m1;
  logic [JW-1:0]   rp_l, rp_k;
  logic [LW:0]     ip1;

  function automatic logic [JW-1:0] ring_pos(input logic [PW-1:0] p,
                                             input logic [CntW-1:0] n);
    logic [PW-1:0] ne;
    logic [PW-1:0] d;
    begin
      ne = PW'(n);
      d  = p - ne;
      ring_pos = (p < ne) ? p[JW-1:0] : d[JW-1:0];
    end
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [DW:0] s;
    begin
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) begin
        sat_add = s[DW] ? cemidp_pkg::SatMin : cemidp_pkg::SatMax;
      end else begin
        sat_add = s[DW-1:0];
      end
    end
  endfunction

  assign r_w     = PW'(l_q) + PW'(len_q) - PW'(1);
  assign kp1_w   = PW'(k_q) + PW'(1);
  assign two_n   = PW'(n_q) + PW'(n_q);
  assign kl_diff = k_q - l_q;
  assign rk_diff = LW'(r_w - kp1_w);
  assign len_m1  = JW'(len_q - CntW'(1));
  assign n_m1    = JW'(n_q - CntW'(1));
  assign rp_l    = ring_pos(PW'(l_q), n_q);
  assign rp_k    = ring_pos(kp1_w, n_q);
  assign ip1     = {1'b0, i_q} + (LW+1)'(1);

  // status flags
  assign status_o.last_vertex = last_vertex_i;
  assign status_o.n_one       = (n_q == CntW'(1));
  assign status_o.l_last      = (PW'(l_q) + PW'(len_q) == two_n);
  assign status_o.len_last    = (len_q == n_q);
  assign status_o.k_last      = (kp1_w == r_w);
  assign status_o.is_mul      = (op_q == cemidp_pkg::OpMul);
  assign status_o.q_last      = (q_q == 2'd3);
  assign status_o.pi_last     = (pi_q == 2'd3);
  assign status_o.i_last      = (PW'(ip1) == PW'(n_q));
  assign status_o.match       = ($signed(iv_rmax) == best_q);
  assign status_o.out_last    = last_res_q;

  // vertex store ports
  assign vs_we    = (cmd_i == cemidp_pkg::CMD_LOAD) && (cnt_q != CntW'(MaxVertices));
  assign vs_waddr = cnt_q[JW-1:0];
  assign vs_raddr = (cmd_i == cemidp_pkg::CMD_L1_RD) ? rp_l : rp_k;

  // interval memory ports
  always_comb begin
    case (cmd_i)
      cemidp_pkg::CMD_RD_R: iv_raddr = {kp1_w[LW-1:0], rk_diff[JW-1:0]};
      cemidp_pkg::CMD_B_RD,
      cemidp_pkg::CMD_O_RD: iv_raddr = {i_q, n_m1};
      default:              iv_raddr = {l_q, kl_diff[JW-1:0]};
    endcase
  end

  always_comb begin
    iv_we    = 1'b0;
    iv_waddr = {l_q, len_m1};
    iv_wmax  = hi_q;
    iv_wmin  = lo_q;
    case (cmd_i)
      cemidp_pkg::CMD_L1_WR: begin
        iv_we    = 1'b1;
        iv_waddr = {l_q, {JW{1'b0}}};
        iv_wmax  = DW'($signed(vs_rdata));
        iv_wmin  = DW'($signed(vs_rdata));
      end
      cemidp_pkg::CMD_SEG_WR: begin
        iv_we = 1'b1;
      end
      default: begin
        iv_we = 1'b0;
      end
    endcase
  end

  // multiplier operand halves and saturated product
  logic [HW-1:0]   a_half, b_half;
  logic [2*DW-1:0] part_sh;
  word_t           a_sel, b_sel, p_sat;
  logic [DW-1:0]   plo;

  assign a_half = q_q[1] ? ua_q[DW-1:HW] : ua_q[HW-1:0];
  assign b_half = q_q[0] ? ub_q[DW-1:HW] : ub_q[HW-1:0];
  assign a_sel  = pi_q[1] ? lmin_q : lmax_q;
  assign b_sel  = pi_q[0] ? rmin_q : rmax_q;
  assign plo    = acc_q[DW-1:0];

  always_comb begin
    case (q_q)
      2'd0:    part_sh = {{DW{1'b0}}, prod_q};
      2'd3:    part_sh = {prod_q, {DW{1'b0}}};
      default: part_sh = {{HW{1'b0}}, prod_q, {HW{1'b0}}};
    endcase
  end

  always_comb begin
    if (acc_q[2*DW-1:DW] != '0) begin
      p_sat = neg_q ? cemidp_pkg::SatMin : cemidp_pkg::SatMax;
    end else if (!neg_q) begin
      p_sat = plo[DW-1] ? cemidp_pkg::SatMax : $signed(plo);
    end else if (plo[DW-1]) begin
      p_sat = cemidp_pkg::SatMin;
    end else begin
      p_sat = $signed(-plo);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      n_q        <= '0;
      len_q      <= '0;
      l_q        <= '0;
      k_q        <= '0;
      i_q        <= '0;
      last_idx_q <= '0;
      q_q        <= '0;
      pi_q       <= '0;
      first_q    <= 1'b0;
      op_q       <= 1'b0;
      last_res_q <= 1'b0;
    end else begin
      case (cmd_i)
        cemidp_pkg::CMD_LOAD: begin
          if (cnt_q != CntW'(MaxVertices)) begin
            cnt_q <= cnt_q + CntW'(1);
            n_q   <= cnt_q + CntW'(1);
          end else begin
            n_q <= cnt_q;
          end
          len_q <= CntW'(1);
          l_q   <= '0;
        end
        cemidp_pkg::CMD_L1_WR: begin
          if (status_o.l_last) begin
            l_q   <= '0;
            len_q <= CntW'(2);
          end else begin
            l_q <= l_q + LW'(1);
          end
        end
        cemidp_pkg::CMD_SEG_START: begin
          k_q     <= l_q;
          first_q <= 1'b1;
        end
        cemidp_pkg::CMD_RD_R: begin
          op_q <= os_rdata[0];
        end
        cemidp_pkg::CMD_MUL_INIT: begin
          q_q <= '0;
        end
        cemidp_pkg::CMD_MUL_A: begin
          q_q <= q_q + 2'd1;
        end
        cemidp_pkg::CMD_MUL_S: begin
          pi_q <= pi_q + 2'd1;
        end
        cemidp_pkg::CMD_MERGE: begin
          first_q <= 1'b0;
          k_q     <= k_q + LW'(1);
          pi_q    <= '0;
        end
        cemidp_pkg::CMD_SEG_WR: begin
          if (status_o.l_last) begin
            l_q   <= '0;
            len_q <= len_q + CntW'(1);
          end else begin
            l_q <= l_q + LW'(1);
          end
        end
        cemidp_pkg::CMD_IDX_CLR: begin
          i_q <= '0;
        end
        cemidp_pkg::CMD_B_CMP: begin
          if (i_q == '0 || $signed(iv_rmax) >= best_q) begin
            last_idx_q <= i_q;
          end
          i_q <= i_q + LW'(1);
        end
        cemidp_pkg::CMD_O_CHK: begin
          last_res_q <= (i_q == last_idx_q);
          if (!status_o.match) begin
            i_q <= i_q + LW'(1);
          end
        end
        cemidp_pkg::CMD_O_SENT: begin
          i_q <= i_q + LW'(1);
          if (last_res_q) begin
            cnt_q <= '0;
          end
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      cemidp_pkg::CMD_RD_R: begin
        lmax_q <= $signed(iv_rmax);
        lmin_q <= $signed(iv_rmin);
      end
      cemidp_pkg::CMD_CAP: begin
        rmax_q <= $signed(iv_rmax);
        rmin_q <= $signed(iv_rmin);
      end
      cemidp_pkg::CMD_ADD: begin
        chi_q <= sat_add(lmax_q, rmax_q);
        clo_q <= sat_add(lmin_q, rmin_q);
      end
      cemidp_pkg::CMD_MUL_INIT: begin
        ua_q  <= a_sel[DW-1] ? -a_sel : a_sel;
        ub_q  <= b_sel[DW-1] ? -b_sel : b_sel;
        neg_q <= a_sel[DW-1] ^ b_sel[DW-1];
        acc_q <= '0;
      end
      cemidp_pkg::CMD_MUL_P: begin
        prod_q <= DW'(a_half * b_half);
      end
      cemidp_pkg::CMD_MUL_A: begin
        acc_q <= acc_q + part_sh;
      end
      cemidp_pkg::CMD_MUL_S: begin
        if (pi_q == 2'd0 || p_sat > chi_q) begin
          chi_q <= p_sat;
        end
        if (pi_q == 2'd0 || p_sat < clo_q) begin
          clo_q <= p_sat;
        end
      end
      cemidp_pkg::CMD_MERGE: begin
        if (first_q || chi_q > hi_q) begin
          hi_q <= chi_q;
        end
        if (first_q || clo_q < lo_q) begin
          lo_q <= clo_q;
        end
      end
      cemidp_pkg::CMD_B_CMP: begin
        if (i_q == '0 || $signed(iv_rmax) > best_q) begin
          best_q <= $signed(iv_rmax);
        end
      end
      cemidp_pkg::CMD_O_CHK: begin
        removed_edge_o <= cemidp_pkg::EdgeW'(ip1);
      end
      default: begin
        hi_q <= hi_q;
      end
    endcase
  end

  assign best_value_o  = best_q;
  assign last_result_o = last_res_q;

  // vertex value and operator stores
  cemidp_ram #(
    .Width (cemidp_pkg::ValW),
    .Depth (2 ** JW)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vs_we),
    .waddr_i (vs_waddr),
    .wdata_i (vertex_value_i),
    .raddr_i (vs_raddr),
    .rdata_o (vs_rdata)
  );

  cemidp_ram #(
    .Width (1),
    .Depth (2 ** JW)
  ) u_op_ram (
    .clk_i   (clk_i),
    .we_i    (vs_we),
    .waddr_i (vs_waddr),
    .wdata_i (edge_op_i),
    .raddr_i (vs_raddr),
    .rdata_o (os_rdata)
  );

  // interval max and min memories
  cemidp_ram #(
    .Width (DW),
    .Depth (2 ** AW)
  ) u_max_ram (
    .clk_i   (clk_i),
    .we_i    (iv_we),
    .waddr_i (iv_waddr),
    .wdata_i (iv_wmax),
    .raddr_i (iv_raddr),
    .rdata_o (iv_rmax)
  );

  cemidp_ram #(
    .Width (DW),
    .Depth (2 ** AW)
  ) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (iv_we),
    .waddr_i (iv_waddr),
    .wdata_i (iv_wmin),
    .raddr_i (iv_raddr),
    .rdata_o (iv_rmin)
  );

endmodule

[hdl/cemidp_ctrl.sv]
// ----------------------------------------------------------------------------
// cemidp_ctrl
// Controller: sequences loading, the interval dp sweep, the maximum scan
// and result delivery by issuing datapath commands.
// ----------------------------------------------------------------------------
module cemidp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  cemidp_pkg::dp_status_t status_i,
  output cemidp_pkg::dp_cmd_e    cmd_o
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_L1_RD = 21'h000002,
    S_L1_WR = 21'h000004,
    S_SEG   = 21'h000008,
    S_RDL   = 21'h000010,
    S_RDR   = 21'h000020,
    S_CAP   = 21'h000040,
    S_ADD   = 21'h000080,
    S_MINIT = 21'h000100,
    S_MP    = 21'h000200,
    S_MA    = 21'h000400,
    S_MS    = 21'h000800,
    S_MERGE = 21'h001000,
    S_WR    = 21'h002000,
    S_BINIT = 21'h004000,
    S_B_RD  = 21'h008000,
    S_B_CMP = 21'h010000,
    S_OINIT = 21'h020000,
    S_O_RD  = 21'h040000,
    S_O_CHK = 21'h080000,
    S_SEND  = 21'h100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SEND);

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = cemidp_pkg::CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = cemidp_pkg::CMD_LOAD;
          if (status_i.last_vertex) begin
            state_d = S_L1_RD;
          end
        end
      end
      S_L1_RD: begin
        cmd_o   = cemidp_pkg::CMD_L1_RD;
        state_d = S_L1_WR;
      end
      S_L1_WR: begin
        cmd_o = cemidp_pkg::CMD_L1_WR;
        if (!status_i.l_last) begin
          state_d = S_L1_RD;
        end else if (status_i.n_one) begin
          state_d = S_BINIT;
        end else begin
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        cmd_o   = cemidp_pkg::CMD_SEG_START;
        state_d = S_RDL;
      end
      S_RDL: begin
        cmd_o   = cemidp_pkg::CMD_RD_L;
        state_d = S_RDR;
      end
      S_RDR: begin
        cmd_o   = cemidp_pkg::CMD_RD_R;
        state_d = S_CAP;
      end
      S_CAP: begin
        cmd_o   = cemidp_pkg::CMD_CAP;
        state_d = status_i.is_mul ? S_MINIT : S_ADD;
      end
      S_ADD: begin
        cmd_o   = cemidp_pkg::CMD_ADD;
        state_d = S_MERGE;
      end
      S_MINIT: begin
        cmd_o   = cemidp_pkg::CMD_MUL_INIT;
        state_d = S_MP;
      end
      S_MP: begin
        cmd_o   = cemidp_pkg::CMD_MUL_P;
        state_d = S_MA;
      end
      S_MA: begin
        cmd_o   = cemidp_pkg::CMD_MUL_A;
        state_d = status_i.q_last ? S_MS : S_MP;
      end
      S_MS: begin
        cmd_o   = cemidp_pkg::CMD_MUL_S;
        state_d = status_i.pi_last ? S_MERGE : S_MINIT;
      end
      S_MERGE: begin
        cmd_o   = cemidp_pkg::CMD_MERGE;
        state_d = status_i.k_last ? S_WR : S_RDL;
      end
      S_WR: begin
        cmd_o   = cemidp_pkg::CMD_SEG_WR;
        state_d = (status_i.l_last && status_i.len_last) ? S_BINIT : S_SEG;
      end
      S_BINIT: begin
        cmd_o   = cemidp_pkg::CMD_IDX_CLR;
        state_d = S_B_RD;
      end
      S_B_RD: begin
        cmd_o   = cemidp_pkg::CMD_B_RD;
        state_d = S_B_CMP;
      end
      S_B_CMP: begin
        cmd_o   = cemidp_pkg::CMD_B_CMP;
        state_d = status_i.i_last ? S_OINIT : S_B_RD;
      end
      S_OINIT: begin
        cmd_o   = cemidp_pkg::CMD_IDX_CLR;
        state_d = S_O_RD;
      end
      S_O_RD: begin
        cmd_o   = cemidp_pkg::CMD_O_RD;
        state_d = S_O_CHK;
      end
      S_O_CHK: begin
        cmd_o   = cemidp_pkg::CMD_O_CHK;
        state_d = status_i.match ? S_SEND : S_O_RD;
      end
      S_SEND: begin
        if (out_ready_i) begin
          cmd_o   = cemidp_pkg::CMD_O_SENT;
          state_d = status_i.out_last ? S_IDLE : S_O_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/circular_expression_max_interval_dp_top.sv]
// ----------------------------------------------------------------------------
// circular_expression_max_interval_dp_top
// Polygon game solver: loads a ring of vertices, runs an interval dp over
// the doubled chain and reports every cut edge that reaches the maximum.
// ----------------------------------------------------------------------------
// Vertices are taken one item per cycle while the block is idle; an item
// with last_vertex set starts the solve, during which no input is accepted.
// The solve is one sequential sweep over a single read port of the interval
// memories: first the single vertices at each position of the doubled chain,
// then every split point of each sub-chain, which is written back after its
// last split point. An add edge takes a saturating add; a multiply edge takes
// four saturated 64x64 products, each built from four 32x32 partial products
// on one shared multiplier. A maximum scan over the vertices follows, and
// results then leave one per output handshake. Results come out with best_value
// repeated for each maximizing edge, last_result marking the final one.
// ----------------------------------------------------------------------------
module circular_expression_max_interval_dp_top #(
  parameter int MaxVertices = cemidp_pkg::MaxVerticesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                edge_op_i,
  input  logic signed [cemidp_pkg::ValW-1:0]  vertex_value_i,
  input  logic                                last_vertex_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cemidp_pkg::DataW-1:0] best_value_o,
  output logic [cemidp_pkg::EdgeW-1:0]        removed_edge_o,
  output logic                                last_result_o
);

  cemidp_pkg::dp_cmd_e    cmd;
  cemidp_pkg::dp_status_t status;

  // sequencing
  cemidp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  cemidp_dp #(
    .MaxVertices (MaxVertices)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .edge_op_i      (edge_op_i),
    .vertex_value_i (vertex_value_i),
    .last_vertex_i  (last_vertex_i),
    .best_value_o   (best_value_o),
    .removed_edge_o (removed_edge_o),
    .last_result_o  (last_result_o)
  );

endmodule
